[hw/rtl/charlieplexed_led_level_decoder_assert.svh]
// Assertion macros used by the charge-indicator level decoder top level.
`ifndef CHARLIEPLEXED_LED_LEVEL_DECODER_ASSERT_SVH
`define CHARLIEPLEXED_LED_LEVEL_DECODER_ASSERT_SVH

// The condition must never hold at a clock edge outside reset.
`define CLD_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("never condition hit");

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define CLD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");

`endif

[hw/rtl/cld_pkg.sv]
// Types, constants and the level-code table of the charge-indicator level decoder.
package cld_pkg;

	localparam int unsigned WinW   = 10;
	localparam int unsigned DutyW  = 11;
	localparam int unsigned LevelW = 10;
	localparam int unsigned CmpW   = 4;
	localparam int unsigned CodeW  = 3;
	localparam int unsigned LedN   = 4;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 11;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CFG_WINDOW_SAMPLES   = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_ON_THRESHOLD     = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_ANALOG_THRESHOLD = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_COMPARE_WINDOWS  = 2'd3;

	// Register values after reset.
	localparam logic [WinW-1:0]   RST_WINDOW_SAMPLES   = 10'd1000;
	localparam logic [DutyW-1:0]  RST_ON_THRESHOLD     = 11'd400;
	localparam logic [LevelW-1:0] RST_ANALOG_THRESHOLD = 10'd500;
	localparam logic [CmpW-1:0]   RST_COMPARE_WINDOWS  = 4'd10;

	// Lit patterns that carry a level, and their codes.
	localparam logic [LedN-1:0] LIT_FOUR  = 4'hF;
	localparam logic [LedN-1:0] LIT_THREE = 4'hE;
	localparam logic [LedN-1:0] LIT_TWO   = 4'hC;
	localparam logic [LedN-1:0] LIT_ONE   = 4'h8;

	localparam logic [CodeW-1:0] CODE_NONE  = 3'd0;
	localparam logic [CodeW-1:0] CODE_ONE   = 3'd1;
	localparam logic [CodeW-1:0] CODE_TWO   = 3'd2;
	localparam logic [CodeW-1:0] CODE_THREE = 3'd4;
	localparam logic [CodeW-1:0] CODE_FOUR  = 3'd6;

	typedef struct packed {
		logic a;
		logic b;
		logic c;
	} sample_t;

	typedef struct packed {
		logic [WinW-1:0]  window_samples;
		logic [DutyW-1:0] on_threshold;
		logic [CmpW-1:0]  compare_windows;
	} cfg_t;

	typedef struct packed {
		logic [CodeW-1:0] level_code;
		logic             charging;
		logic [LedN-1:0]  lit_pattern;
	} result_t;

	function automatic logic [CodeW-1:0] code_of(input logic [LedN-1:0] lit);
		logic [CodeW-1:0] code;
		case (lit)
			LIT_FOUR:  code = CODE_FOUR;
			LIT_THREE: code = CODE_THREE;
			LIT_TWO:   code = CODE_TWO;
			LIT_ONE:   code = CODE_ONE;
			default:   code = CODE_NONE;
		endcase
		return code;
	endfunction

endpackage

[hw/rtl/cld_sample_stage.sv]
// Input register: takes one pin sample and resolves the analog pin to a level.
module cld_sample_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          pin_one,
	input  logic                          pin_two,
	input  logic [cld_pkg::LevelW-1:0]    pin_three_level,
	input  logic [cld_pkg::LevelW-1:0]    analog_threshold,
	input  logic                          advance,
	output logic                          valid_s1,
	output cld_pkg::sample_t              sample_s1
);

	logic take;

	// The held sample blocks a new one only when it cannot move on.
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1.a <= pin_one;
			sample_s1.b <= pin_two;
			sample_s1.c <= pin_three_level > analog_threshold;
		end
	end

endmodule

[hw/rtl/cld_measure.sv]
// Duty counters, window end, lit pattern and the measurement sequence.
module cld_measure (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  cld_pkg::sample_t  sample,
	input  cld_pkg::cfg_t     cfg,
	output logic              emit,
	output cld_pkg::result_t  result
);

	logic [cld_pkg::WinW-1:0]  sample_count_q;
	logic [cld_pkg::DutyW-1:0] duty_q [cld_pkg::LedN];
	logic [cld_pkg::CmpW-1:0]  window_index_q;
	logic [cld_pkg::CodeW-1:0] first_code_q;

	logic [1:0]                inc [cld_pkg::LedN];
	logic [cld_pkg::DutyW-1:0] duty_nx [cld_pkg::LedN];
	logic [cld_pkg::WinW-1:0]  count_nx;
	logic [cld_pkg::WinW-1:0]  win_len;
	logic                      win_end;
	logic [cld_pkg::LedN-1:0]  lit;
	logic [cld_pkg::CodeW-1:0] code;
	logic [cld_pkg::CodeW-1:0] max_code;
	logic                      differs;

	always_comb begin
		// Each LED gains one for its direct condition and one more when the
		// two digital pins disagree in its favour.
		inc[0] = {1'b0, sample.a && !sample.c} + {1'b0, sample.a && !sample.b};
		inc[1] = {1'b0, !sample.a && sample.c} + {1'b0, !sample.a && sample.b};
		inc[2] = {1'b0, sample.b && !sample.c} + {1'b0, !sample.a && sample.b};
		inc[3] = {1'b0, !sample.b && sample.c} + {1'b0, sample.a && !sample.b};
		for (int i = 0; i < cld_pkg::LedN; i++) begin
			duty_nx[i] = duty_q[i] + {{(cld_pkg::DutyW-2){1'b0}}, inc[i]};
			lit[cld_pkg::LedN-1-i] = duty_nx[i] > cfg.on_threshold;
		end
		count_nx = sample_count_q + 1'b1;
		win_len  = (cfg.window_samples == '0) ? {{(cld_pkg::WinW-1){1'b0}}, 1'b1}
		                                      : cfg.window_samples;
		win_end  = count_nx >= win_len;
		code     = cld_pkg::code_of(lit);
		differs  = code != first_code_q;
		max_code = (code > first_code_q) ? code : first_code_q;
	end

	always_comb begin
		emit   = 1'b0;
		result = '{level_code: first_code_q, charging: 1'b0, lit_pattern: lit};
		if (win_end) begin
			if (window_index_q == '0) begin
				emit              = cfg.compare_windows == '0;
				result.level_code = code;
			end else if (differs) begin
				emit              = 1'b1;
				result.level_code = max_code;
				result.charging   = 1'b1;
			end else begin
				emit = window_index_q >= cfg.compare_windows;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= '0;
			window_index_q <= '0;
			first_code_q   <= '0;
			for (int i = 0; i < cld_pkg::LedN; i++) begin
				duty_q[i] <= '0;
			end
		end else if (step) begin
			if (win_end) begin
				sample_count_q <= '0;
				for (int i = 0; i < cld_pkg::LedN; i++) begin
					duty_q[i] <= '0;
				end
				if (window_index_q == '0) begin
					first_code_q <= code;
				end
				if (emit) begin
					window_index_q <= '0;
				end else begin
					window_index_q <= window_index_q + 1'b1;
				end
			end else begin
				sample_count_q <= count_nx;
				for (int i = 0; i < cld_pkg::LedN; i++) begin
					duty_q[i] <= duty_nx[i];
				end
			end
		end
	end

endmodule

[hw/rtl/charlieplexed_led_level_decoder.sv]
// Top level of the charge-indicator level decoder: configuration, handshakes, result register.
//
//  Channel   Direction  Handshake            Payload
//  input     in         in_valid / in_stall  pin_one, pin_two, pin_three_level
//  result    out        out_valid / out_stall level_code, charging, lit_pattern
//  config    in         cfg_we               cfg_index, cfg_data
//
// One pin sample is taken every cycle while in_stall is low. A sample passes through the input register
// and then updates the counters; a result is loaded into the result register when the
// sample that ends its measurement moves on from the input register, and is offered
// with out_valid from that same edge on.
// Reset is asynchronous and restores the default window, thresholds and compare count.
// A stall on the result side holds the input only when the waiting sample would
// finish a measurement while the previous result is still held.
`include "charlieplexed_led_level_decoder_assert.svh"

module charlieplexed_led_level_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            pin_one,
	input  logic                            pin_two,
	input  logic [cld_pkg::LevelW-1:0]      pin_three_level,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [cld_pkg::CodeW-1:0]       level_code,
	output logic                            charging,
	output logic [cld_pkg::LedN-1:0]        lit_pattern,
	input  logic                            cfg_we,
	input  logic [cld_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [cld_pkg::CfgDataW-1:0]    cfg_data
);

	// Configuration registers.
	logic [cld_pkg::WinW-1:0]   window_samples_q;
	logic [cld_pkg::DutyW-1:0]  on_threshold_q;
	logic [cld_pkg::LevelW-1:0] analog_threshold_q;
	logic [cld_pkg::CmpW-1:0]   compare_windows_q;
	cld_pkg::cfg_t              cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_samples_q   <= cld_pkg::RST_WINDOW_SAMPLES;
			on_threshold_q     <= cld_pkg::RST_ON_THRESHOLD;
			analog_threshold_q <= cld_pkg::RST_ANALOG_THRESHOLD;
			compare_windows_q  <= cld_pkg::RST_COMPARE_WINDOWS;
		end else if (cfg_we) begin
			case (cfg_index)
				cld_pkg::CFG_WINDOW_SAMPLES:   window_samples_q   <= cfg_data[cld_pkg::WinW-1:0];
				cld_pkg::CFG_ON_THRESHOLD:     on_threshold_q     <= cfg_data[cld_pkg::DutyW-1:0];
				cld_pkg::CFG_ANALOG_THRESHOLD: analog_threshold_q <= cfg_data[cld_pkg::LevelW-1:0];
				cld_pkg::CFG_COMPARE_WINDOWS:  compare_windows_q  <= cfg_data[cld_pkg::CmpW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = '{window_samples: window_samples_q, on_threshold: on_threshold_q,
	               compare_windows: compare_windows_q};

	// Sample stage and measurement logic.
	logic             valid_s1;
	cld_pkg::sample_t sample_s1;
	logic             advance;
	logic             emit;
	logic             out_free;
	logic             load;
	cld_pkg::result_t result;
	cld_pkg::result_t res_q;
	logic             out_valid_q;

	// The result register can take a new item when empty or being emptied now.
	assign out_free = !out_valid_q || !out_stall;
	// A sample that finishes nothing may always move on; one that ends a
	// measurement needs room in the result register.
	assign advance  = valid_s1 && (!emit || out_free);
	assign load     = advance && emit;

	cld_sample_stage u_sample (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.pin_one          (pin_one),
		.pin_two          (pin_two),
		.pin_three_level  (pin_three_level),
		.analog_threshold (analog_threshold_q),
		.advance          (advance),
		.valid_s1         (valid_s1),
		.sample_s1        (sample_s1)
	);

	cld_measure u_measure (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.sample (sample_s1),
		.cfg    (cfg),
		.emit   (emit),
		.result (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign level_code  = res_q.level_code;
	assign charging    = res_q.charging;
	assign lit_pattern = res_q.lit_pattern;

	// A held, stalled result is never overwritten.
	`CLD_ASSERT_NEVER(a_no_overwrite, clk, arst_n, out_valid_q && out_stall && load)
	// An empty input register never holds the input back.
	`CLD_ASSERT_IMPLIES(a_empty_no_stall, clk, arst_n, !valid_s1, !in_stall)
	// A charging result reports the larger of two different codes, so never zero.
	`CLD_ASSERT_IMPLIES(a_charge_code, clk, arst_n, out_valid && charging,
		level_code != cld_pkg::CODE_NONE)
	// Only the five level codes can appear.
	`CLD_ASSERT_IMPLIES(a_code_set, clk, arst_n, out_valid,
		level_code == cld_pkg::CODE_NONE || level_code == cld_pkg::CODE_ONE ||
		level_code == cld_pkg::CODE_TWO || level_code == cld_pkg::CODE_THREE ||
		level_code == cld_pkg::CODE_FOUR)

endmodule
